@@ rtl/core/bti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and constants for the breakpoint table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int IDX_W  = 6;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result region codes
  typedef enum logic [1:0] {
    REG_INSIDE = 2'd0,
    REG_BELOW  = 2'd1,
    REG_ABOVE  = 2'd2
  } region_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_YRD0,
    ST_YRD1,
    ST_YRD2,
    ST_DIVW,
    ST_RND,
    ST_FIN
  } state_t;

endpackage

@@ rtl/core/bti_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_table
// Breakpoint storage: x and y memories, one write port shared by both,
// one registered read port on each.
// ----------------------------------------------------------------------------
module bti_table
  import bti_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_POINTS)-1:0] waddr,
  input  logic signed [DATA_W-1:0]      wx,
  input  logic signed [DATA_W-1:0]      wy,
  input  logic [$clog2(MAX_POINTS)-1:0] x_raddr,
  input  logic [$clog2(MAX_POINTS)-1:0] y_raddr,
  output logic signed [DATA_W-1:0]      x_rdata,
  output logic signed [DATA_W-1:0]      y_rdata
);

  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];

  // x memory
  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[waddr] <= wx;
    end
    x_rdata <= x_mem[x_raddr];
  end

  // y memory
  always_ff @(posedge clk) begin
    if (we) begin
      y_mem[waddr] <= wy;
    end
    y_rdata <= y_mem[y_raddr];
  end

endmodule

@@ rtl/core/bti_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_div
// Restoring divider for the interpolation fraction:
// quo = floor(num * 2^FRAC_BITS / den), with num <= den, one bit per cycle.
// ----------------------------------------------------------------------------
module bti_div
  import bti_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DATA_W-1:0]    num,
  input  logic [DATA_W-1:0]    den,
  output logic [FRAC_BITS:0]   quo,
  output logic                 busy,
  output logic                 done
);

  localparam int SW = $clog2(FRAC_BITS + 2);

  logic [SW-1:0]     cnt;
  logic              first;
  logic [DATA_W:0]   rem;
  logic [DATA_W-1:0] dreg;
  logic [DATA_W+1:0] cand;
  logic [DATA_W+1:0] diff;
  logic              ge;

  // trial subtract; first step uses the numerator unshifted
  always_comb begin
    cand = first ? {1'b0, rem} : {rem, 1'b0};
    diff = cand - {2'b00, dreg};
    ge   = (cand >= {2'b00, dreg});
  end

  assign busy = (cnt != '0);

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= SW'(FRAC_BITS + 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      dreg  <= den;
      first <= 1'b1;
    end else if (busy) begin
      rem   <= ge ? diff[DATA_W:0] : cand[DATA_W:0];
      quo   <= {quo[FRAC_BITS-1:0], ge};
      first <= 1'b0;
    end
  end

endmodule

@@ rtl/core/breakpoint_table_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator_unit
// Piecewise linear lookup table over signed fixed-point breakpoints.
// ----------------------------------------------------------------------------
// A load writes one breakpoint and gives no result. A query scans the x
// memory one slot per cycle from slot 0 until the first x not below query_x
// or the last active slot, so its length grows with the slot that matches,
// set by the linear scan over the single x read port and, for an
// interpolated query, by the one-bit-per-cycle divider. busy stays high for
// the whole query; the result is shown for exactly one cycle with done high
// and cannot be stalled. points_in_use is sampled at query start and may be
// written at any time.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator_unit
  import bti_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind,
  input  logic [IDX_W-1:0]         point_index,
  input  logic signed [DATA_W-1:0] point_x,
  input  logic signed [DATA_W-1:0] point_y,
  input  logic signed [DATA_W-1:0] query_x,
  // result
  output logic                     done,
  output logic signed [DATA_W-1:0] value,
  output logic [1:0]               region,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = DATA_W + FRAC_BITS + 3;
  localparam logic signed [PW-1:0] HALF   = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] SAT_HI = PW'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic signed [PW-1:0] SAT_LO =
    {{(PW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  state_t state, state_next;

  logic [CFG_W-1:0]         points_in_use;
  logic [CW-1:0]            n_eff;
  logic [CW-1:0]            n_pts;
  logic [CW-1:0]            rd_idx;
  logic [CW-1:0]            cmp_idx;
  logic                     cmp_vld;
  logic signed [DATA_W-1:0] qx;
  logic signed [DATA_W-1:0] prev_x;
  logic [AW-1:0]            y_addr0;
  logic [AW-1:0]            y_addr1;
  logic                     clamp;
  region_t                  reg_code;
  logic signed [DATA_W-1:0] y0;
  logic signed [DATA_W-1:0] y1;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     rnd;
  logic signed [PW-1:0]     sum;
  logic signed [DATA_W:0]   dy;

  logic                     accept;
  logic                     tbl_we;
  logic [AW-1:0]            x_raddr;
  logic [AW-1:0]            y_raddr;
  logic signed [DATA_W-1:0] x_rdata;
  logic signed [DATA_W-1:0] y_rdata;
  logic                     hit;
  logic                     last;

  logic                     div_start;
  logic [DATA_W-1:0]        div_num;
  logic [DATA_W-1:0]        div_den;
  logic [FRAC_BITS:0]       div_quo;
  logic                     div_busy;
  logic                     div_done;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  // search length, clamped to the table
  always_comb begin
    if (points_in_use < CFG_W'(2)) begin
      n_eff = CW'(2);
    end else if (int'(points_in_use) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(points_in_use);
    end
  end

  // table access
  assign tbl_we  = accept && (kind == KIND_LOAD) && (int'(point_index) < MAX_POINTS);
  assign x_raddr = rd_idx[AW-1:0];
  assign y_raddr = (state == ST_YRD1) ? y_addr1 : y_addr0;

  bti_table #(
    .MAX_POINTS(MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (AW'(point_index)),
    .wx      (point_x),
    .wy      (point_y),
    .x_raddr (x_raddr),
    .y_raddr (y_raddr),
    .x_rdata (x_rdata),
    .y_rdata (y_rdata)
  );

  // scan compare on the slot whose x is on the read port
  assign hit  = cmp_vld && (x_rdata >= qx);
  assign last = cmp_vld && (cmp_idx == n_pts - 1'b1);

  // fraction divider, started as soon as both x neighbors are known
  assign div_start = (state == ST_SCAN) && hit && (cmp_idx != '0);
  assign div_num   = DATA_W'(qx - prev_x);
  assign div_den   = DATA_W'(x_rdata - prev_x);

  bti_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .busy  (div_busy),
    .done  (div_done)
  );

  // interpolation arithmetic
  assign dy  = {y1[DATA_W-1], y1} - {y0[DATA_W-1], y0};
  assign sum = PW'(y0) + rnd;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_QUERY)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || last) state_next = ST_YRD0;
      end
      ST_YRD0: state_next = ST_YRD1;
      ST_YRD1: state_next = clamp ? ST_IDLE : ST_YRD2;
      ST_YRD2: state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) state_next = ST_RND;
      end
      ST_RND:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == ST_YRD1) && clamp) || (state == ST_FIN);
    end
  end

  // scan compare valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else if (accept) begin
      cmp_vld <= 1'b0;
    end else if (state == ST_SCAN) begin
      cmp_vld <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        rd_idx <= '0;
        qx     <= query_x;
        n_pts  <= n_eff;
      end
      ST_SCAN: begin
        if (hit) begin
          clamp <= (cmp_idx == '0);
          if (cmp_idx == '0) begin
            reg_code <= REG_BELOW;
            y_addr0  <= '0;
          end else begin
            reg_code <= REG_INSIDE;
            y_addr0  <= AW'(cmp_idx - 1'b1);
            y_addr1  <= cmp_idx[AW-1:0];
          end
        end else if (last) begin
          clamp    <= 1'b1;
          reg_code <= REG_ABOVE;
          y_addr0  <= cmp_idx[AW-1:0];
        end else begin
          rd_idx  <= rd_idx + 1'b1;
          cmp_idx <= rd_idx;
          prev_x  <= x_rdata;
        end
      end
      ST_YRD1: begin
        y0 <= y_rdata;
        if (clamp) begin
          value  <= y_rdata;
          region <= reg_code;
        end
      end
      ST_YRD2: y1 <= y_rdata;
      ST_DIVW: begin
        if (div_done) prod <= PW'(dy) * PW'($signed({1'b0, div_quo}));
      end
      ST_RND:  rnd <= (prod + HALF) >>> FRAC_BITS;
      ST_FIN: begin
        region <= REG_INSIDE;
        if (sum > SAT_HI) begin
          value <= SAT_HI[DATA_W-1:0];
        end else if (sum < SAT_LO) begin
          value <= SAT_LO[DATA_W-1:0];
        end else begin
          value <= sum[DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while a query is still running");

  a_done_after_query: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result strobe without a query");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cmp_vld) |-> (cmp_idx < n_pts))
    else $error("scan ran past the active table");

endmodule

@@ tb/tb_breakpoint_table_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breakpoint_table_interpolator_unit
// Self-checking bench for the breakpoint table interpolator. Loads breakpoint
// tables (sorted and scrambled), runs lookups near and away from breakpoints
// across several points_in_use settings, and checks every result against an
// in-bench predictor of the lookup arithmetic.
// ----------------------------------------------------------------------------
module tb_breakpoint_table_interpolator_unit;
  import bti_pkg::*;

  localparam int NPTS        = DEF_MAX_POINTS;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int TARGET      = 1200;
  localparam int SETTLE      = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int S32_MIN     = 32'sh8000_0000;
  localparam int S32_MAX     = 32'sh7fff_ffff;

  typedef struct {
    logic                     kind;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] qx;
  } cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    region_t                  region;
  } lookup_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     kind = KIND_LOAD;
  logic [IDX_W-1:0]         point_index = '0;
  logic signed [DATA_W-1:0] point_x = '0;
  logic signed [DATA_W-1:0] point_y = '0;
  logic signed [DATA_W-1:0] query_x = '0;
  logic                     done;
  logic signed [DATA_W-1:0] value;
  logic [1:0]               region;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data = '0;

  breakpoint_table_interpolator_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .query_x(query_x), .done(done), .value(value), .region(region),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [DATA_W-1:0] tbl_x [NPTS];
  logic signed [DATA_W-1:0] tbl_y [NPTS];
  logic [CFG_W-1:0]         pts_cfg = 7'd2;

  cmd_t    cmd_q[$];
  lookup_t lookup_q[$];
  int      err_count = 0;
  int      cycles = 0;
  int      gap = 0;
  bit      steady = 0;
  logic    xfer_seen = 1'b0;

  // expected lookup result for the current table and setting
  function automatic lookup_t predict_lookup(input logic signed [DATA_W-1:0] q);
    lookup_t r;
    int      n, i;
    longint  x0, x1, y0, y1, t, v;
    n = (pts_cfg < 2) ? 2 : ((pts_cfg > NPTS) ? NPTS : pts_cfg);
    for (i = 0; i < n; i++) begin
      if (tbl_x[i] >= q) break;
    end
    if (i == 0) begin
      r.value = tbl_y[0];
      r.region = REG_BELOW;
    end else if (i >= n) begin
      r.value = tbl_y[n-1];
      r.region = REG_ABOVE;
    end else begin
      x0 = tbl_x[i-1];
      x1 = tbl_x[i];
      y0 = tbl_y[i-1];
      y1 = tbl_y[i];
      t = ((longint'(q) - x0) <<< FRAC) / (x1 - x0);
      // floor with half-up rounding
      v = y0 + (((y1 - y0) * t + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
      if (v > S32_MAX) v = S32_MAX;
      if (v < S32_MIN) v = S32_MIN;
      r.value = v[31:0];
      r.region = REG_INSIDE;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // command driver, changes on the falling edge
  always @(negedge clk) begin
    cmd_t c;
    if (!rst && !(start && !xfer_seen)) begin
      if (gap > 0) begin
        start <= 1'b0;
        gap <= gap - 1;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        start <= 1'b1;
        kind <= c.kind;
        point_index <= c.idx;
        point_x <= c.px;
        point_y <= c.py;
        query_x <= c.qx;
        gap <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result checker and transfer tracking
  always @(posedge clk) begin
    lookup_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst) begin
      if (done) begin
        if (lookup_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result value=%0d region=%0d", $time, value, region);
        end else begin
          e = lookup_q.pop_front();
          if (value !== e.value) begin
            err_count++;
            $display("%0t: value expected %0d actual %0d", $time, e.value, value);
          end
          if (region !== e.region) begin
            err_count++;
            $display("%0t: region expected %0d actual %0d", $time, e.region, region);
          end
        end
      end
      xfer_seen <= start && !busy;
      if (start && !busy) begin
        if (kind == KIND_LOAD) begin
          tbl_x[point_index] = point_x;
          tbl_y[point_index] = point_y;
        end else begin
          lookup_q.push_back(predict_lookup(query_x));
        end
      end
    end
  end

  function automatic void add_load(input int i, input int x, input int y);
    cmd_t c;
    c.kind = KIND_LOAD; c.idx = i; c.px = x; c.py = y; c.qx = $urandom;
    cmd_q.push_back(c);
  endfunction

  function automatic void add_query(input int q);
    cmd_t c;
    c.kind = KIND_QUERY; c.idx = $urandom; c.px = $urandom; c.py = $urandom; c.qx = q;
    cmd_q.push_back(c);
  endfunction

  // full sorted table; dense tables keep spacing small
  function automatic void add_table(input bit dense, output int xs[NPTS]);
    int ys[NPTS];
    int base;
    base = int'($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < NPTS; i++) begin
      if (dense) begin
        base += $urandom_range(1, 3000);
        xs[i] = base;
        ys[i] = int'($urandom_range(0, 200000)) - 100000;
      end else begin
        xs[i] = $urandom;
        ys[i] = $urandom;
      end
    end
    xs.sort();
    for (int i = 0; i < NPTS; i++) add_load(i, xs[i], ys[i]);
  endfunction

  // let everything in flight finish before touching the register
  task automatic drain();
    do @(posedge clk); while (cmd_q.size() != 0 || start || lookup_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_points(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    pts_cfg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int xs[NPTS];
    int n, total, nq, s, r;
    logic [CFG_W-1:0] cfg_pick [6];

    cfg_pick = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: table spanning the full range with extreme y swings
    write_points(7'd64);
    add_table(1'b0, xs);
    add_load(0, S32_MIN, S32_MAX);
    add_load(1, xs[1], S32_MIN);
    add_load(NPTS - 1, S32_MAX, S32_MIN);
    xs[0] = S32_MIN;
    xs[NPTS-1] = S32_MAX;
    add_query(S32_MIN);                    // at first x
    add_query(S32_MAX);                    // equal to last x
    add_query(xs[1]);                      // equal to inner x
    add_query(xs[0] + 1);
    add_query(xs[0] + (xs[1] - xs[0]) / 2);
    add_query(xs[20]);
    add_query(xs[20] + 1);
    drain();
    write_points(7'd0);                    // acts as two points
    add_query(S32_MAX);
    add_query(xs[1] + 1);
    add_query(xs[1]);
    drain();
    write_points(7'd127);                  // acts as the full table
    add_query(xs[NPTS-1] - 1);
    add_query(S32_MAX);
    drain();
    write_points(7'd1);
    add_query(S32_MIN + 1);
    add_query(xs[1]);
    drain();

    // random phases
    total = 0;
    while (total < TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      write_points(r < 4 ? cfg_pick[$urandom_range(0, 5)] : $urandom_range(2, 64));
      n = (pts_cfg < 2) ? 2 : ((pts_cfg > NPTS) ? NPTS : pts_cfg);
      if ($urandom_range(0, 2) != 0) begin
        add_table($urandom_range(0, 1), xs);
        total += NPTS;
      end else begin
        for (int i = 0; i < NPTS; i++) xs[i] = tbl_x[i];
      end
      // a few stray loads scramble the order
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < 4; k++) begin
          s = $urandom_range(0, NPTS - 1);
          xs[s] = $urandom;
          add_load(s, xs[s], $urandom);
          total++;
        end
      end
      nq = $urandom_range(30, 90);
      for (int k = 0; k < nq; k++) begin
        s = $urandom_range(0, n - 1);
        r = $urandom_range(0, 9);
        if (r < 5) add_query(xs[s] - int'($urandom_range(0, 4000)) + 1);
        else if (r < 7) add_query(xs[s]);
        else if (r < 8) add_query(xs[n-1] + int'($urandom_range(1, 100)));
        else add_query($urandom);
      end
      total += nq;
      drain();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bti_pkg.sv
rtl/core/bti_table.sv
rtl/core/bti_div.sv
rtl/core/breakpoint_table_interpolator_unit.sv
tb/tb_breakpoint_table_interpolator_unit.sv
